// ===== design/tcyc_pkg.sv =====
package tcyc_pkg;

    // Event kinds carried on the input channel's tuser.
    localparam logic [2:0] REQ_START  = 3'd0;
    localparam logic [2:0] REQ_STOP   = 3'd1;
    localparam logic [2:0] REQ_PAUSE  = 3'd2;
    localparam logic [2:0] REQ_RESUME = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DURATION = 2'd0;
    localparam logic [1:0] CFG_FOREVER  = 2'd1;
    localparam logic [1:0] CFG_REPEAT   = 2'd2;
    localparam logic [1:0] CFG_BOUNCE   = 2'd3;

    // Fixed field widths.
    localparam int TIME_W   = 32;
    localparam int REPEAT_W = 16;
    localparam int REQ_W    = 3;
    localparam int FLAGS_W  = 3;
    localparam int CFG_AW   = 2;

    // Reset values of the configuration.
    localparam logic [TIME_W-1:0]   DURATION_RST = 32'd1000;
    localparam logic [REPEAT_W-1:0] REPEAT_RST   = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an input transfer completes this cycle
        logic eval;      // clamp elapsed time, update tween state, seed divider
        logic div_step;  // one quotient bit
        logic out_load;  // move the finished result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_run;  // offered item is a tick and the tween is not paused
        logic div_last;  // this divider step produces the last quotient bit
        logic out_free;  // output register can take a new result
    } ctrl_sts_t;

endpackage

// ===== design/tween_cycle_timer.sv =====
// Channel  Direction  tdata                          tuser
// s_       in         [31:0] event_time              [2:0] req_type
// m_       out        [FRAC:0] progress, zero pad    [0] reversed [1] cycle_done [2] finished
//
// Start, stop, pause, resume and a paused tick are handled at the input transfer
// and leave the block ready for the next event. A tick with a result takes the
// transfer, clamps the elapsed time and updates state, then runs the restoring
// divider one step per fraction bit, then loads the output register.
// A result waiting on m_tready holds the block in its final state.
// aresetn is synchronous and active low; it resets the configuration, the tween
// state, the controller, the divider count and the output valid, while the other
// per-tick working registers carry no reset.
module tween_cycle_timer #(
    parameter int PROGRESS_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tcyc_pkg::TIME_W-1:0]          s_tdata,   // event_time
    input  logic [tcyc_pkg::REQ_W-1:0]           s_tuser,   // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((PROGRESS_FRAC_BITS+8)/8)*8-1:0] m_tdata, // progress, zero fill
    output logic [tcyc_pkg::FLAGS_W-1:0]         m_tuser,   // reversed, cycle_done, finished
    input  logic                                 cfg_wr_en,
    input  logic [tcyc_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [tcyc_pkg::TIME_W-1:0]          cfg_wdata
);

    localparam int DATA_W = ((PROGRESS_FRAC_BITS + 8) / 8) * 8;

    tcyc_pkg::ctrl_cmd_t cmd;
    tcyc_pkg::ctrl_sts_t sts;

    tcyc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcyc_dp #(
        .FRAC_BITS (PROGRESS_FRAC_BITS),
        .DATA_W    (DATA_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // A running tick keeps the input closed while it is evaluated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.tick_run) |=> !s_tready)
        else $error("input accepted during tick evaluation");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending transfer");

    // Finishing only happens at the end of a cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1] || !m_tuser[2]))
        else $error("finished without cycle_done");

    // Progress never exceeds full scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PROGRESS_FRAC_BITS:0] <=
                      ((PROGRESS_FRAC_BITS+1)'(1) << PROGRESS_FRAC_BITS)))
        else $error("progress above full scale");
`endif

endmodule

// ===== design/tcyc_ctrl.sv =====
module tcyc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tcyc_pkg::ctrl_sts_t sts,
    output tcyc_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.tick_run) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tcyc_dp.sv =====
module tcyc_dp #(
    parameter int FRAC_BITS = 16,
    parameter int DATA_W    = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcyc_pkg::ctrl_cmd_t           cmd,
    output tcyc_pkg::ctrl_sts_t           sts,
    input  logic [tcyc_pkg::TIME_W-1:0]   s_tdata,
    input  logic [tcyc_pkg::REQ_W-1:0]    s_tuser,
    input  logic                          cfg_wr_en,
    input  logic [tcyc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tcyc_pkg::TIME_W-1:0]   cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [DATA_W-1:0]             m_tdata,
    output logic [tcyc_pkg::FLAGS_W-1:0]  m_tuser
);

    localparam int TW    = tcyc_pkg::TIME_W;
    localparam int RW    = tcyc_pkg::REPEAT_W;
    localparam int PW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    // Configuration.
    logic [TW-1:0] duration_reg, duration_next;
    logic          forever_reg, forever_next;
    logic          bounce_reg, bounce_next;

    // Tween state.
    logic          active_reg, active_next;
    logic          paused_reg, paused_next;
    logic          reverse_reg, reverse_next;
    logic [TW-1:0] origin_reg, origin_next;
    logic [TW-1:0] ptotal_reg, ptotal_next;
    logic [TW-1:0] porigin_reg, porigin_next;
    logic [RW-1:0] left_reg, left_next;

    // Per-tick working registers.
    logic [TW-1:0]    elapsed_reg, elapsed_next;
    logic             dir_reg, dir_next;
    logic             done_reg, done_next;
    logic             fin_reg, fin_next;
    logic             zdur_reg, zdur_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Output register.
    logic          ovalid_reg, ovalid_next;
    logic [PW-1:0] oprog_reg, oprog_next;
    logic [tcyc_pkg::FLAGS_W-1:0] oflags_reg, oflags_next;

    logic          complete;
    logic [TW:0]   rem_shift;
    logic          rem_ge;

    assign complete  = (elapsed_reg >= duration_reg);
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, duration_reg});

    assign sts.tick_run = (s_tuser == tcyc_pkg::REQ_TICK) && !paused_reg;
    assign sts.div_last = (cnt_reg == CNT_W'(1));
    assign sts.out_free = !ovalid_reg || m_tready;

    // Configuration writes, events, tick evaluation and division steps.
    always_comb begin
        duration_next = duration_reg;
        forever_next  = forever_reg;
        bounce_next   = bounce_reg;
        active_next   = active_reg;
        paused_next   = paused_reg;
        reverse_next  = reverse_reg;
        origin_next   = origin_reg;
        ptotal_next   = ptotal_reg;
        porigin_next  = porigin_reg;
        left_next     = left_reg;
        elapsed_next  = elapsed_reg;
        dir_next      = dir_reg;
        done_next     = done_reg;
        fin_next      = fin_reg;
        zdur_next     = zdur_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                tcyc_pkg::CFG_DURATION: duration_next = cfg_wdata;
                tcyc_pkg::CFG_FOREVER:  forever_next  = cfg_wdata[0];
                tcyc_pkg::CFG_REPEAT:   left_next     = cfg_wdata[RW-1:0];
                tcyc_pkg::CFG_BOUNCE:   bounce_next   = cfg_wdata[0];
                default: ;
            endcase
        end

        // Event handling at the input transfer.
        if (cmd.accept) begin
            unique case (s_tuser)
                tcyc_pkg::REQ_START: begin
                    active_next  = 1'b1;
                    origin_next  = s_tdata;
                    reverse_next = 1'b0;
                end
                tcyc_pkg::REQ_STOP: begin
                    if (active_reg) begin
                        active_next = 1'b0;
                        ptotal_next = '0;
                    end
                end
                tcyc_pkg::REQ_PAUSE: begin
                    paused_next  = 1'b1;
                    porigin_next = s_tdata;
                end
                tcyc_pkg::REQ_RESUME: begin
                    paused_next  = 1'b0;
                    ptotal_next  = ptotal_reg + (s_tdata - porigin_reg);
                    porigin_next = '0;
                end
                tcyc_pkg::REQ_TICK: begin
                    if (!paused_reg) begin
                        elapsed_next = s_tdata - origin_reg - ptotal_reg;
                    end
                end
                default: ;
            endcase
        end

        // Clamp, end-of-cycle handling and divider seed. The top quotient
        // bit is one exactly when the cycle is complete.
        if (cmd.eval) begin
            dir_next  = reverse_reg;
            zdur_next = (duration_reg == '0);
            done_next = 1'b0;
            fin_next  = 1'b0;
            quo_next  = PW'(complete);
            rem_next  = complete ? '0 : elapsed_reg;
            cnt_next  = CNT_W'(FRAC_BITS);
            if (active_reg && complete) begin
                done_next = 1'b1;
                if (!forever_reg && (left_reg <= RW'(1))) begin
                    active_next = 1'b0;
                    ptotal_next = '0;
                    fin_next    = 1'b1;
                end else begin
                    if (!forever_reg) begin
                        left_next = left_reg - RW'(1);
                    end
                    if (bounce_reg) begin
                        reverse_next = !reverse_reg;
                    end
                    origin_next = origin_reg + duration_reg;
                end
            end
        end

        // Restoring division, one quotient bit per cycle.
        if (cmd.div_step) begin
            rem_next = rem_ge ? TW'(rem_shift - {1'b0, duration_reg}) : rem_shift[TW-1:0];
            quo_next = {quo_reg[PW-2:0], rem_ge};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output register: a zero duration reports full scale.
    always_comb begin
        ovalid_next = ovalid_reg;
        oprog_next  = oprog_reg;
        oflags_next = oflags_reg;
        if (m_tready) begin
            ovalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            ovalid_next = 1'b1;
            oprog_next  = zdur_reg ? (PW'(1) << FRAC_BITS) : quo_reg;
            oflags_next = {fin_reg, done_reg, dir_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg <= tcyc_pkg::DURATION_RST;
            forever_reg  <= 1'b0;
            bounce_reg   <= 1'b0;
            active_reg   <= 1'b0;
            paused_reg   <= 1'b0;
            reverse_reg  <= 1'b0;
            origin_reg   <= '0;
            ptotal_reg   <= '0;
            porigin_reg  <= '0;
            left_reg     <= tcyc_pkg::REPEAT_RST;
            cnt_reg      <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            duration_reg <= duration_next;
            forever_reg  <= forever_next;
            bounce_reg   <= bounce_next;
            active_reg   <= active_next;
            paused_reg   <= paused_next;
            reverse_reg  <= reverse_next;
            origin_reg   <= origin_next;
            ptotal_reg   <= ptotal_next;
            porigin_reg  <= porigin_next;
            left_reg     <= left_next;
            cnt_reg      <= cnt_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        dir_reg     <= dir_next;
        done_reg    <= done_next;
        fin_reg     <= fin_next;
        zdur_reg    <= zdur_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        oprog_reg   <= oprog_next;
        oflags_reg  <= oflags_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = DATA_W'(oprog_reg);
    assign m_tuser  = oflags_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC          = 16;
    localparam int MDATA_W       = ((FRAC + 8) / 8) * 8;
    localparam int SETTLE_CYCLES = FRAC + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 100;

    // One tick report as the block should give it.
    typedef struct packed {
        logic [FRAC:0] progress;
        logic          reversed;
        logic          cycle_done;
        logic          finished;
    } tick_result_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [tcyc_pkg::TIME_W-1:0]     s_tdata   = '0;   // event_time
    logic [tcyc_pkg::REQ_W-1:0]      s_tuser   = '0;   // req_type
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [MDATA_W-1:0]              m_tdata;          // progress, zero fill
    logic [tcyc_pkg::FLAGS_W-1:0]    m_tuser;          // reversed, cycle_done, finished
    logic                            cfg_wr_en = 1'b0;
    logic [tcyc_pkg::CFG_AW-1:0]     cfg_addr  = '0;
    logic [tcyc_pkg::TIME_W-1:0]     cfg_wdata = '0;

    // Configuration and tween state as the block should hold them.
    logic [tcyc_pkg::TIME_W-1:0]     cfg_duration = tcyc_pkg::DURATION_RST;
    logic                            cfg_forever  = 1'b0;
    logic                            cfg_bounce   = 1'b0;
    logic                            tw_active    = 1'b0;
    logic                            tw_paused    = 1'b0;
    logic                            tw_reverse   = 1'b0;
    logic [tcyc_pkg::TIME_W-1:0]     tw_origin    = '0;
    logic [tcyc_pkg::TIME_W-1:0]     tw_pause_sum = '0;
    logic [tcyc_pkg::TIME_W-1:0]     tw_pause_at  = '0;
    logic [tcyc_pkg::REPEAT_W-1:0]   tw_repeats   = tcyc_pkg::REPEAT_RST;

    tick_result_t pending_ticks[$];
    int error_count = 0;
    int burst_left  = 0;
    int rx_run      = 0;
    int rx_stall    = 0;
    int cycle_count = 0;

    tween_cycle_timer #(
        .PROGRESS_FRAC_BITS(FRAC)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one accepted event to the tween state and queue the tick report it causes.
    function automatic void tween_event(input logic [tcyc_pkg::REQ_W-1:0] kind,
                                        input logic [tcyc_pkg::TIME_W-1:0] t);
        logic [tcyc_pkg::TIME_W-1:0] span;
        logic                        complete;
        logic [63:0]                 quotient;
        tick_result_t                res;
        case (kind)
            tcyc_pkg::REQ_START: begin
                tw_active  = 1'b1;
                tw_origin  = t;
                tw_reverse = 1'b0;
            end
            tcyc_pkg::REQ_STOP: begin
                if (tw_active) begin
                    tw_active    = 1'b0;
                    tw_pause_sum = '0;
                end
            end
            tcyc_pkg::REQ_PAUSE: begin
                tw_paused   = 1'b1;
                tw_pause_at = t;
            end
            tcyc_pkg::REQ_RESUME: begin
                tw_paused    = 1'b0;
                tw_pause_sum = tw_pause_sum + (t - tw_pause_at);
                tw_pause_at  = '0;
            end
            tcyc_pkg::REQ_TICK: begin
                if (!tw_paused) begin
                    span     = t - tw_origin - tw_pause_sum;
                    complete = (span >= cfg_duration);
                    if (complete) begin
                        span = cfg_duration;
                    end
                    if (cfg_duration == '0) begin
                        quotient = 64'd1 << FRAC;
                    end else begin
                        quotient = ({32'd0, span} << FRAC) / {32'd0, cfg_duration};
                    end
                    res.progress   = quotient[FRAC:0];
                    res.reversed   = tw_reverse;
                    res.cycle_done = tw_active && complete;
                    res.finished   = 1'b0;
                    // End of a cycle: stop, or go on with the next one.
                    if (tw_active && complete) begin
                        if (!cfg_forever && tw_repeats <= 16'd1) begin
                            tw_active    = 1'b0;
                            tw_pause_sum = '0;
                            res.finished = 1'b1;
                        end else begin
                            if (!cfg_forever) begin
                                tw_repeats = tw_repeats - 16'd1;
                            end
                            if (cfg_bounce) begin
                                tw_reverse = ~tw_reverse;
                            end
                            tw_origin = tw_origin + span;
                        end
                    end
                    pending_ticks.push_back(res);
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one event in bursts with random gaps, and predict once the transfer happens.
    task automatic send_event(input logic [tcyc_pkg::REQ_W-1:0] kind,
                              input logic [tcyc_pkg::TIME_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tween_event(kind, t);
    endtask

    // Write one configuration register; the predictor follows at the same edge.
    task automatic write_reg(input logic [tcyc_pkg::CFG_AW-1:0] idx,
                             input logic [tcyc_pkg::TIME_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            tcyc_pkg::CFG_DURATION: cfg_duration = value;
            tcyc_pkg::CFG_FOREVER:  cfg_forever  = value[0];
            tcyc_pkg::CFG_REPEAT:   tw_repeats   = value[tcyc_pkg::REPEAT_W-1:0];
            tcyc_pkg::CFG_BOUNCE:   cfg_bounce   = value[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending, wait for every queued report, then let the block run dry.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Ticks and a stop with the reset configuration and no tween running.
    task automatic test_inactive_ticks();
        send_event(tcyc_pkg::REQ_TICK, 32'd0);
        send_event(tcyc_pkg::REQ_TICK, 32'd500);
        send_event(tcyc_pkg::REQ_TICK, 32'hFFFF_FFFF);
        send_event(tcyc_pkg::REQ_STOP, 32'd42);
    endtask

    // Pause twice, resume twice (once while running), then run past the end.
    task automatic test_pause_resume();
        send_event(tcyc_pkg::REQ_START,  32'd100);
        send_event(tcyc_pkg::REQ_TICK,   32'd600);
        send_event(tcyc_pkg::REQ_PAUSE,  32'd700);
        send_event(tcyc_pkg::REQ_TICK,   32'd800);
        send_event(tcyc_pkg::REQ_PAUSE,  32'd750);
        send_event(tcyc_pkg::REQ_RESUME, 32'd850);
        send_event(tcyc_pkg::REQ_TICK,   32'd1150);
        send_event(tcyc_pkg::REQ_RESUME, 32'd900);
        send_event(tcyc_pkg::REQ_TICK,   32'hFFFF_FFFF);
    endtask

    // Undefined request codes must leave the state alone.
    task automatic test_ignored_codes();
        for (int k = tcyc_pkg::REQ_TICK + 1; k < 8; k++) begin
            send_event((tcyc_pkg::REQ_W)'(k), $urandom);
        end
        send_event(tcyc_pkg::REQ_TICK, 32'd2000);
    endtask

    // Zero duration completes every cycle at once; bounce flips each time.
    task automatic test_zero_duration();
        settle_block();
        write_reg(tcyc_pkg::CFG_DURATION, 32'd0);
        write_reg(tcyc_pkg::CFG_FOREVER,  32'd1);
        write_reg(tcyc_pkg::CFG_REPEAT,   32'h0000_FFFF);
        write_reg(tcyc_pkg::CFG_BOUNCE,   32'd1);
        send_event(tcyc_pkg::REQ_START, 32'd5);
        send_event(tcyc_pkg::REQ_TICK,  32'd5);
        send_event(tcyc_pkg::REQ_TICK,  32'd9);
    endtask

    // Largest duration with two repeats and time wrapping around.
    task automatic test_long_duration();
        settle_block();
        write_reg(tcyc_pkg::CFG_DURATION, 32'hFFFF_FFFF);
        write_reg(tcyc_pkg::CFG_FOREVER,  32'd0);
        write_reg(tcyc_pkg::CFG_REPEAT,   32'd2);
        write_reg(tcyc_pkg::CFG_BOUNCE,   32'd1);
        send_event(tcyc_pkg::REQ_START, 32'd0);
        send_event(tcyc_pkg::REQ_TICK,  32'h7FFF_FFFF);
        send_event(tcyc_pkg::REQ_TICK,  32'hFFFF_FFFF);
        send_event(tcyc_pkg::REQ_TICK,  32'hFFFF_FFFE);
    endtask

    // Phases of mostly well-formed tween traffic under changing settings.
    task automatic test_random_phases();
        logic [tcyc_pkg::TIME_W-1:0]   dur;
        logic [tcyc_pkg::REPEAT_W-1:0] reps;
        logic [tcyc_pkg::TIME_W-1:0]   now_t;
        logic [tcyc_pkg::TIME_W-1:0]   step;
        logic                          gen_paused;
        int                            r;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: dur = 32'd1;
                1: dur = 32'hFFFF_FFFF;
                2: dur = 32'd0;
                default: begin
                    case ($urandom_range(0, 3))
                        0: dur = $urandom_range(1, 64);
                        1: dur = $urandom_range(65, 5000);
                        default: dur = $urandom;
                    endcase
                end
            endcase
            case (p % 4)
                0: reps = 16'd0;
                1: reps = 16'hFFFF;
                default: reps = $urandom_range(1, 6);
            endcase
            settle_block();
            write_reg(tcyc_pkg::CFG_DURATION, dur);
            write_reg(tcyc_pkg::CFG_FOREVER,  {31'($urandom), 1'(p % 3 == 2)});
            write_reg(tcyc_pkg::CFG_REPEAT,   {16'($urandom), reps});
            write_reg(tcyc_pkg::CFG_BOUNCE,   {31'($urandom), 1'(p % 2 == 1)});

            now_t      = $urandom;
            gen_paused = 1'b0;
            send_event(tcyc_pkg::REQ_START, now_t);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // Noise: any code at any time.
                    send_event((tcyc_pkg::REQ_W)'($urandom), $urandom);
                end else if (r < 20) begin
                    now_t = now_t + $urandom_range(0, 7);
                    if (r < 12) begin
                        send_event(tcyc_pkg::REQ_START, now_t);
                    end else if (r < 15) begin
                        send_event(tcyc_pkg::REQ_STOP, now_t);
                    end else if (!gen_paused) begin
                        send_event(tcyc_pkg::REQ_PAUSE, now_t);
                        gen_paused = 1'b1;
                    end else begin
                        send_event(tcyc_pkg::REQ_RESUME, now_t);
                        gen_paused = 1'b0;
                    end
                end else if (r < 23 || (gen_paused && r < 45)) begin
                    now_t = now_t + $urandom_range(0, 50);
                    send_event(tcyc_pkg::REQ_RESUME, now_t);
                    gen_paused = 1'b0;
                end else begin
                    // Tick after a step that is mostly a fraction of the cycle.
                    case ($urandom_range(0, 9))
                        0: step = $urandom;
                        1: step = cfg_duration;
                        default: begin
                            if (cfg_duration == '0) begin
                                step = $urandom_range(0, 3);
                            end else begin
                                step = $urandom_range(0, cfg_duration / 3 + 1);
                            end
                        end
                    endcase
                    now_t = now_t + step;
                    send_event(tcyc_pkg::REQ_TICK, now_t);
                end
            end
        end
    endtask

    // Receiver: ready runs and stalls of random length, with long runs now and then.
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            m_tready <= 1'b1;
        end else begin
            rx_run   = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
            rx_stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 4);
        end
    end

    // Compare each result transfer with the oldest queued tick report.
    always @(posedge aclk) begin : check_tick_result
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ticks.size() == 0) begin
                $error("result transfer with no tick report pending");
                error_count++;
            end else begin
                want = pending_ticks.pop_front();
                if (m_tdata[FRAC:0] !== want.progress) begin
                    $error("progress: expected %0d, actual %0d", want.progress, m_tdata[FRAC:0]);
                    error_count++;
                end
                if (m_tuser[0] !== want.reversed) begin
                    $error("reversed: expected %0b, actual %0b", want.reversed, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.cycle_done) begin
                    $error("cycle_done: expected %0b, actual %0b", want.cycle_done, m_tuser[1]);
                    error_count++;
                end
                if (m_tuser[2] !== want.finished) begin
                    $error("finished: expected %0b, actual %0b", want.finished, m_tuser[2]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_inactive_ticks();
        test_pause_resume();
        test_ignored_codes();
        test_zero_duration();
        test_long_duration();
        test_random_phases();
        settle_block();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
